FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the translator RTL.
// Each macro samples on the rising edge of clk and is disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/ugt_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ugt_pkg
// Types, codes and UTF-8 helper functions for the glyph translator.
// ---------------------------------------------------------------------------
package ugt_pkg;

	localparam int unsigned TABLE_DEPTH = 16;
	localparam int unsigned IDX_W       = 4;
	localparam int unsigned CP_W        = 21;
	localparam int unsigned ACTIVE_W    = 5;
	localparam int unsigned IN_TDATA_W  = 56;
	localparam int unsigned OUT_TDATA_W = 16;

	typedef logic [CP_W-1:0]  cp_t;
	typedef logic [7:0]       byte_t;
	typedef logic [3:0][7:0]  glyph_bytes_t;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_TEXT = 1'b1
	} op_t;

	typedef enum logic {
		KIND_TEXT   = 1'b0,
		KIND_STATUS = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		LOAD_OK           = 2'd0,
		LOAD_DUPLICATE    = 2'd1,
		LOAD_BEYOND_COUNT = 2'd2,
		LOAD_LEN_MISMATCH = 2'd3
	} load_status_t;

	typedef enum logic {
		REG_ACTIVE_ENTRIES = 1'b0,
		REG_SAME_LENGTH    = 1'b1
	} cfg_reg_t;

	// One input request as registered at the input stage.
	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] idx;
		cp_t              old_cp;
		cp_t              new_cp;
		byte_t            text;
		logic             eos;
	} item_t;

	// Up to four result bytes of one request; count zero means no result.
	typedef struct packed {
		kind_t        kind;
		glyph_bytes_t bytes;
		logic [2:0]   count;
		load_status_t status;
		logic         eos;
	} result_t;

	// Decoded glyph: ok when complete, well formed and eligible for lookup.
	typedef struct packed {
		logic ok;
		cp_t  cp;
	} glyph_key_t;

	// Table lookup answer.
	typedef struct packed {
		logic hit;
		cp_t  new_cp;
	} match_t;

	// Number of UTF-8 bytes needed for a codepoint.
	function automatic logic [2:0] enc_len(cp_t cp);
		logic [2:0] n;
		if (cp < 21'h80) begin
			n = 3'd1;
		end else if (cp < 21'h800) begin
			n = 3'd2;
		end else if (cp < 21'h10000) begin
			n = 3'd3;
		end else begin
			n = 3'd4;
		end
		return n;
	endfunction

	// UTF-8 bytes of a codepoint, first byte in the lowest lane.
	function automatic glyph_bytes_t encode(cp_t cp);
		glyph_bytes_t b;
		b = '0;
		case (enc_len(cp))
			3'd1: begin
				b[0] = cp[7:0];
			end
			3'd2: begin
				b[0] = {3'b110, cp[10:6]};
				b[1] = {2'b10, cp[5:0]};
			end
			3'd3: begin
				b[0] = {4'b1110, cp[15:12]};
				b[1] = {2'b10, cp[11:6]};
				b[2] = {2'b10, cp[5:0]};
			end
			default: begin
				b[0] = {5'b11110, cp[20:18]};
				b[1] = {2'b10, cp[17:12]};
				b[2] = {2'b10, cp[11:6]};
				b[3] = {2'b10, cp[5:0]};
			end
		endcase
		return b;
	endfunction

	// Glyph length announced by a lead byte; zero for a byte that cannot lead.
	function automatic logic [2:0] lead_len(byte_t b);
		logic [2:0] n;
		if (!b[7]) begin
			n = 3'd1;
		end else if (b[7:6] == 2'b10) begin
			n = 3'd0;
		end else if (b[7:5] == 3'b110) begin
			n = 3'd2;
		end else if (b[7:4] == 4'b1110) begin
			n = 3'd3;
		end else if (b[7:3] == 5'b11110) begin
			n = 3'd4;
		end else begin
			n = 3'd0;
		end
		return n;
	endfunction

	// Codepoint of a gathered glyph; ok is cleared by a bad trailing byte.
	function automatic glyph_key_t decode_glyph(glyph_bytes_t g, logic [2:0] n);
		glyph_key_t k;
		k.ok = 1'b1;
		k.cp = '0;
		case (n)
			3'd1: begin
				k.cp = {14'b0, g[0][6:0]};
			end
			3'd2: begin
				k.cp = {10'b0, g[0][4:0], g[1][5:0]};
				k.ok = (g[1][7:6] == 2'b10);
			end
			3'd3: begin
				k.cp = {5'b0, g[0][3:0], g[1][5:0], g[2][5:0]};
				k.ok = (g[1][7:6] == 2'b10) && (g[2][7:6] == 2'b10);
			end
			3'd4: begin
				k.cp = {g[0][2:0], g[1][5:0], g[2][5:0], g[3][5:0]};
				k.ok = (g[1][7:6] == 2'b10) && (g[2][7:6] == 2'b10)
					&& (g[3][7:6] == 2'b10);
			end
			default: begin
				k.ok = 1'b0;
			end
		endcase
		return k;
	endfunction

endpackage

FILE: rtl/ugt_table.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// ugt_table
// Translation table: storage, parallel lookup and load checking.
// ---------------------------------------------------------------------------
module ugt_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [ugt_pkg::ACTIVE_W-1:0]  active_entries,
	input  logic                          same_length_only,
	input  ugt_pkg::item_t                item,
	input  logic                          load_fire,
	input  ugt_pkg::glyph_key_t           key,
	output ugt_pkg::match_t               match,
	output ugt_pkg::load_status_t         load_status
);
	import ugt_pkg::*;

	cp_t                    old_q [TABLE_DEPTH];
	cp_t                    new_q [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] valid_q;

	logic [ACTIVE_W-1:0]    active_cnt;
	cp_t                    key_cp;
	logic [TABLE_DEPTH-1:0] eq;
	logic [TABLE_DEPTH-1:0] idx_hot;
	logic                   dup;
	logic                   table_we;

	// Count of entries in use, capped at the table depth.
	assign active_cnt = (active_entries > ACTIVE_W'(TABLE_DEPTH)) ?
		ACTIVE_W'(TABLE_DEPTH) : active_entries;

	// One comparator bank serves both the glyph lookup and the duplicate check.
	assign key_cp = (item.op == OP_LOAD) ? item.old_cp : key.cp;

	always_comb begin
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			eq[k]      = valid_q[k] && (old_q[k] == key_cp);
			idx_hot[k] = (IDX_W'(k) == item.idx);
		end
	end

	// Lowest matching active entry wins.
	always_comb begin
		match = '0;
		for (int k = TABLE_DEPTH - 1; k >= 0; k--) begin
			if (key.ok && eq[k] && (ACTIVE_W'(k) < active_cnt)) begin
				match.hit    = 1'b1;
				match.new_cp = new_q[k];
			end
		end
	end

	// Load checks in priority order.
	assign dup = |(eq & ~idx_hot);

	always_comb begin
		if (dup) begin
			load_status = LOAD_DUPLICATE;
		end else if ({1'b0, item.idx} >= active_cnt) begin
			load_status = LOAD_BEYOND_COUNT;
		end else if (same_length_only
				&& (enc_len(item.old_cp) != enc_len(item.new_cp))) begin
			load_status = LOAD_LEN_MISMATCH;
		end else begin
			load_status = LOAD_OK;
		end
	end

	assign table_we = load_fire && (load_status == LOAD_OK);

	// Entry payload; only read behind a set valid bit.
	always_ff @(posedge clk) begin
		if (table_we) begin
			old_q[item.idx] <= item.old_cp;
			new_q[item.idx] <= item.new_cp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (table_we) begin
			valid_q[item.idx] <= 1'b1;
		end
	end

	`ASSERT_NEXT(a_written_entry_valid, table_we, valid_q[$past(item.idx)],
		"accepted load did not leave its entry valid")

endmodule

FILE: rtl/ugt_glyph.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// ugt_glyph
// Gathers text bytes into glyphs, decodes them and builds the output bytes.
// ---------------------------------------------------------------------------
module ugt_glyph (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ugt_pkg::byte_t       text,
	input  logic                 eos,
	input  logic                 update,
	input  ugt_pkg::match_t      match,
	output ugt_pkg::glyph_key_t  key,
	output ugt_pkg::result_t     result
);
	import ugt_pkg::*;

	byte_t        pend_q [3];
	logic [1:0]   pend_cnt_q;
	logic [2:0]   exp_len_q;

	glyph_bytes_t glyph;
	logic [2:0]   n;
	logic [2:0]   eff_len;
	logic         complete;
	logic         done;
	glyph_key_t   dec;

	// Pending bytes followed by the new byte.
	always_comb begin
		glyph = '0;
		for (int k = 0; k < 3; k++) begin
			if (2'(k) < pend_cnt_q) begin
				glyph[k] = pend_q[k];
			end
		end
		glyph[pend_cnt_q] = text;
	end

	assign n        = {1'b0, pend_cnt_q} + 3'd1;
	assign eff_len  = (pend_cnt_q == 2'd0) ? lead_len(text) : exp_len_q;
	assign complete = (eff_len == 3'd0) || (n >= eff_len);
	assign done     = complete || eos;

	// Only a complete glyph with a valid lead and good trailing bytes is looked up.
	assign dec    = decode_glyph(glyph, n);
	assign key.ok = complete && (eff_len != 3'd0) && dec.ok;
	assign key.cp = dec.cp;

	// Translated, passed through, or nothing while the glyph is still open.
	always_comb begin
		result.kind   = KIND_TEXT;
		result.status = LOAD_OK;
		result.eos    = eos;
		if (!done) begin
			result.bytes = '0;
			result.count = 3'd0;
		end else if (key.ok && match.hit) begin
			result.bytes = encode(match.new_cp);
			result.count = enc_len(match.new_cp);
		end else begin
			result.bytes = glyph;
			result.count = n;
		end
	end

	// Pending byte storage; entries past the count are never read.
	always_ff @(posedge clk) begin
		if (update && !done) begin
			for (int k = 0; k < 3; k++) begin
				if (2'(k) == pend_cnt_q) begin
					pend_q[k] <= text;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_cnt_q <= 2'd0;
			exp_len_q  <= 3'd0;
		end else if (update) begin
			if (done) begin
				pend_cnt_q <= 2'd0;
				exp_len_q  <= 3'd0;
			end else begin
				pend_cnt_q <= n[1:0];
				if (pend_cnt_q == 2'd0) begin
					exp_len_q <= eff_len;
				end
			end
		end
	end

	`ASSERT_IMPLIES(a_pending_short, pend_cnt_q != 2'd0, 3'(pend_cnt_q) < exp_len_q,
		"pending glyph is not shorter than its expected length")
	`ASSERT_IMPLIES(a_idle_no_len, pend_cnt_q == 2'd0, exp_len_q == 3'd0,
		"expected length kept with no pending glyph")

endmodule

FILE: rtl/ugt_out.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// ugt_out
// Result register that sends the bytes of one request one per cycle while m_tready is high.
// ---------------------------------------------------------------------------
module ugt_out (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ugt_pkg::result_t                   rec,
	input  logic                               load,
	output logic                               free,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [ugt_pkg::OUT_TDATA_W-1:0]    m_tdata,  // out_byte, load_status, string_end
	output logic                               m_tlast,  // last_of_run
	output logic                               m_tuser   // result_kind
);
	import ugt_pkg::*;

	result_t    res_s2;
	logic       valid_s2;
	logic [1:0] pos_q;
	logic       last;
	byte_t      cur_byte;

	assign last     = (3'(pos_q) == (res_s2.count - 3'd1));
	assign free     = !valid_s2 || (m_tready && last);
	assign cur_byte = res_s2.bytes[pos_q];

	assign m_tvalid = valid_s2;
	assign m_tlast  = last;
	assign m_tuser  = res_s2.kind;
	assign m_tdata  = {5'b0, last & res_s2.eos, res_s2.status, cur_byte};

	// Result payload.
	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= rec;
		end
	end

	// Occupancy and byte position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			pos_q    <= 2'd0;
		end else if (load) begin
			valid_s2 <= 1'b1;
			pos_q    <= 2'd0;
		end else if (valid_s2 && m_tready) begin
			if (last) begin
				valid_s2 <= 1'b0;
			end else begin
				pos_q <= pos_q + 2'd1;
			end
		end
	end

	`ASSERT_IMPLIES(a_load_when_free, load, free, "result register overwritten")
	`ASSERT_IMPLIES(a_pos_in_range, valid_s2,
		(res_s2.count != 3'd0) && (res_s2.count <= 3'd4) && (3'(pos_q) < res_s2.count),
		"byte position outside the held result")
	`ASSERT_IMPLIES(a_status_single, valid_s2 && (res_s2.kind == KIND_STATUS),
		res_s2.count == 3'd1, "load status result is not a single item")

endmodule

FILE: rtl/utf8_glyph_translate.sv
`timescale 1ns / 1ps
// A request is captured in the input register on acceptance; its result is then
// loaded into the result register, which drives m_tvalid, once that register is free.
// One request per cycle while the result register can take it; results leave one byte
// per cycle while m_tready is high; a result holds the register until its last byte.
// Reset clears all table valid bits, any pending glyph and both config registers.
// ---------------------------------------------------------------------------
// utf8_glyph_translate
// Character translator for a UTF-8 byte stream with a loadable 16-entry table.
// ---------------------------------------------------------------------------
module utf8_glyph_translate (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic                               cfg_index,
	input  logic [ugt_pkg::ACTIVE_W-1:0]       cfg_wdata,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// entry_index, old_codepoint, new_codepoint, text_byte, zero fill
	input  logic [ugt_pkg::IN_TDATA_W-1:0]     s_tdata,
	input  logic                               s_tlast,  // end_of_string
	input  logic                               s_tuser,  // operation
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// out_byte, load_status, string_end, zero fill
	output logic [ugt_pkg::OUT_TDATA_W-1:0]    m_tdata,
	output logic                               m_tlast,  // last_of_run
	output logic                               m_tuser   // result_kind
);
	import ugt_pkg::*;

	logic [ACTIVE_W-1:0] active_entries_q;
	logic                same_length_q;

	item_t        item_in;
	item_t        item_s1;
	logic         valid_s1;

	glyph_key_t   key;
	match_t       match;
	load_status_t load_status;
	result_t      glyph_res;
	result_t      rec;
	logic         out_free;
	logic         produces;
	logic         s1_fire;
	logic         load_fire;
	logic         text_fire;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_entries_q <= '0;
			same_length_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_ACTIVE_ENTRIES: active_entries_q <= cfg_wdata;
				REG_SAME_LENGTH:    same_length_q    <= cfg_wdata[0];
				default:            ;
			endcase
		end
	end

	// Unpack the input request.
	always_comb begin
		item_in.op     = op_t'(s_tuser);
		item_in.idx    = s_tdata[3:0];
		item_in.old_cp = s_tdata[24:4];
		item_in.new_cp = s_tdata[45:25];
		item_in.text   = s_tdata[53:46];
		item_in.eos    = s_tlast;
	end

	// A request leaves the input register when it yields nothing or the
	// result register can take it.
	assign produces  = (item_s1.op == OP_LOAD) || (glyph_res.count != 3'd0);
	assign s1_fire   = valid_s1 && (!produces || out_free);
	assign s_tready  = !valid_s1 || s1_fire;
	assign load_fire = s1_fire && (item_s1.op == OP_LOAD);
	assign text_fire = s1_fire && (item_s1.op == OP_TEXT);

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	ugt_table u_table (
		.clk              (clk),
		.arst_n           (arst_n),
		.active_entries   (active_entries_q),
		.same_length_only (same_length_q),
		.item             (item_s1),
		.load_fire        (load_fire),
		.key              (key),
		.match            (match),
		.load_status      (load_status)
	);

	ugt_glyph u_glyph (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (item_s1.text),
		.eos    (item_s1.eos),
		.update (text_fire),
		.match  (match),
		.key    (key),
		.result (glyph_res)
	);

	// Load requests answer with a single status result.
	always_comb begin
		if (item_s1.op == OP_LOAD) begin
			rec.kind   = KIND_STATUS;
			rec.bytes  = '0;
			rec.count  = 3'd1;
			rec.status = load_status;
			rec.eos    = 1'b0;
		end else begin
			rec = glyph_res;
		end
	end

	ugt_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.rec      (rec),
		.load     (s1_fire && produces),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule
